// ===== rtl/lcr_pkg.sv =====
// lcr_pkg: shared types and constants of the load cell serial reader
// no dependencies; imported by lcr_div, load_cell_adc_serial_reader and tb
`default_nettype none
package lcr_pkg;

  localparam int TARE_W   = 24;
  localparam int DIV_W    = 23;
  localparam int WEIGHT_W = 25;
  localparam int WEIGHT_MAX = 16777215;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TARE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SHIFT,
    PH_EXTRA,
    PH_DONE
  } phase_t;

  typedef enum logic {
    CT_RUN,
    CT_DIV
  } ctl_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lcr_div.sv =====
// lcr_div: iterative restoring divider, one quotient bit per cycle
// depends on lcr_pkg (divider control and status structs, divisor width)
`default_nettype none
module lcr_div #(
  parameter int W = 25
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  lcr_pkg::div_ctrl_t       ctrl,
  input  wire  [W-1:0]             dividend,
  input  wire  [lcr_pkg::DIV_W-1:0] divisor,
  output lcr_pkg::div_stat_t       stat,
  output logic [W-1:0]             quotient
);
  import lcr_pkg::*;

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
    if (ctrl.ack) begin
      done_nxt = 1'b0;
    end
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // restoring step: keep the difference when no borrow
      if (!diff[DIV_W+1]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/load_cell_adc_serial_reader.sv =====
// load_cell_adc_serial_reader: top level, pin sequencer, config registers, output register
// depends on lcr_pkg and lcr_div
//
// Each request is one tick of the converter's slow clock and carries the sampled data pin.
// Each tick but the one that reports the weight is taken when in_stall is low and gives its
// result in the output register on the next cycle. The tick that reports the weight starts the
// restoring divider, which settles one quotient bit per cycle, and in_stall stays high
// until the weight has been written to the output register.
// in_stall is also high while a result waits in the output register under out_stall.
// Configuration writes take effect at once and belong between reads.
`default_nettype none
module load_cell_adc_serial_reader #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_start_req,
  input  wire                               in_dout,
  input  wire                               in_power_down,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_sck,
  output logic                              out_busy_res,
  output logic                              out_result_valid,
  output logic signed [lcr_pkg::WEIGHT_W-1:0] out_weight,
  input  wire                               cfg_we,
  input  wire  [lcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [lcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lcr_pkg::*;

  localparam int BC_W = $clog2(SAMPLE_BITS);
  localparam int DW   = ((SAMPLE_BITS > TARE_W) ? SAMPLE_BITS : TARE_W) + 1;
  localparam int QW   = (DW > WEIGHT_W) ? DW : WEIGHT_W;

  // config registers
  logic [TARE_W-1:0] tare_r;
  logic [DIV_W-1:0]  cal_r;
  logic              gain_r;

  // pin sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [BC_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [SAMPLE_BITS-1:0] shift_r, shift_nxt;
  logic [1:0]             extra_r, extra_nxt;
  logic                   sck_r, sck_nxt;
  logic                   done_tick;

  // request handling and output register
  ctl_t                 ctl_r, ctl_nxt;
  logic                 accept;
  logic                 neg_r, neg_nxt;
  logic                 ov_r, ov_nxt;
  logic                 osck_r, osck_nxt;
  logic                 obusy_r, obusy_nxt;
  logic                 orv_r, orv_nxt;
  logic [WEIGHT_W-1:0]  ow_r, ow_nxt;

  // divider interface
  div_ctrl_t       div_ctrl;
  div_stat_t       div_st;
  logic [DW-1:0]   raw_x, tare_x, diff, mag;
  logic [DIV_W-1:0] dsr;
  logic [DW-1:0]   quo;
  logic [QW-1:0]   quo_x;
  logic [WEIGHT_W-1:0] qmag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tare_r <= '0;
      cal_r  <= DIV_W'(1);
      gain_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARE:    tare_r <= cfg_wdata[TARE_W-1:0];
        CFG_DIVISOR: cal_r  <= cfg_wdata[DIV_W-1:0];
        CFG_GAIN:    gain_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = (ctl_r == CT_DIV) || (ov_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      extra_r   <= '0;
      sck_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      extra_r   <= extra_nxt;
      sck_r     <= sck_nxt;
    end
  end

  always_comb begin
    phase_t ph;
    ph          = phase_r;
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    extra_nxt   = extra_r;
    sck_nxt     = sck_r;
    done_tick   = 1'b0;
    if (in_power_down) begin
      phase_nxt   = PH_IDLE;
      bit_cnt_nxt = '0;
      extra_nxt   = '0;
      sck_nxt     = 1'b1;
    end else begin
      if (ph == PH_IDLE) begin
        sck_nxt = 1'b0;
        if (in_start_req) begin
          ph = PH_WAIT;
        end
      end
      unique case (ph)
        PH_IDLE: ;
        PH_WAIT: begin
          // converter ready when data pin is low
          if (!in_dout) begin
            sck_nxt     = 1'b1;
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
            ph          = PH_SHIFT;
          end
        end
        PH_SHIFT: begin
          if (sck_r) begin
            shift_nxt = {shift_r[SAMPLE_BITS-2:0], in_dout};
            sck_nxt   = 1'b0;
            if (bit_cnt_r == BC_W'(SAMPLE_BITS - 1)) begin
              bit_cnt_nxt = '0;
              extra_nxt   = gain_r ? 2'd3 : 2'd1;
              ph          = PH_EXTRA;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 1'b1;
            end
          end else begin
            sck_nxt = 1'b1;
          end
        end
        PH_EXTRA: begin
          if (sck_r) begin
            sck_nxt   = 1'b0;
            extra_nxt = extra_r - 1'b1;
            if (extra_r == 2'd1) begin
              ph = PH_DONE;
            end
          end else begin
            sck_nxt = 1'b1;
          end
        end
        PH_DONE: begin
          done_tick = 1'b1;
          sck_nxt   = 1'b0;
          ph        = PH_IDLE;
        end
        default: begin
          sck_nxt = 1'b0;
          ph      = PH_IDLE;
        end
      endcase
      phase_nxt = ph;
    end
  end

  // tared sample and its magnitude for the divider
  assign raw_x  = {{(DW-SAMPLE_BITS){shift_r[SAMPLE_BITS-1]}}, shift_r};
  assign tare_x = {{(DW-TARE_W){tare_r[TARE_W-1]}}, tare_r};
  assign diff   = raw_x - tare_x;
  assign mag    = diff[DW-1] ? (~diff + 1'b1) : diff;
  assign dsr    = (cal_r == '0) ? DIV_W'(1) : cal_r;

  lcr_div #(
    .W(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (mag),
    .divisor  (dsr),
    .stat     (div_st),
    .quotient (quo)
  );

  assign quo_x = QW'(quo);
  assign qmag  = (quo_x > QW'(WEIGHT_MAX)) ? WEIGHT_W'(WEIGHT_MAX) : quo_x[WEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= CT_RUN;
      ov_r  <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
      ov_r  <= ov_nxt;
    end
    neg_r   <= neg_nxt;
    osck_r  <= osck_nxt;
    obusy_r <= obusy_nxt;
    orv_r   <= orv_nxt;
    ow_r    <= ow_nxt;
  end

  always_comb begin
    ctl_nxt        = ctl_r;
    neg_nxt        = neg_r;
    ov_nxt         = ov_r && out_stall;
    osck_nxt       = osck_r;
    obusy_nxt      = obusy_r;
    orv_nxt        = orv_r;
    ow_nxt         = ow_r;
    div_ctrl.start = 1'b0;
    div_ctrl.ack   = 1'b0;
    unique case (ctl_r)
      CT_RUN: begin
        if (accept) begin
          if (done_tick) begin
            div_ctrl.start = 1'b1;
            neg_nxt        = diff[DW-1];
            ctl_nxt        = CT_DIV;
          end else begin
            ov_nxt    = 1'b1;
            osck_nxt  = sck_nxt;
            obusy_nxt = (phase_nxt != PH_IDLE);
            orv_nxt   = 1'b0;
            ow_nxt    = '0;
          end
        end
      end
      CT_DIV: begin
        if (div_st.done && !(ov_r && out_stall)) begin
          div_ctrl.ack = 1'b1;
          ov_nxt       = 1'b1;
          osck_nxt     = 1'b0;
          obusy_nxt    = 1'b0;
          orv_nxt      = 1'b1;
          ow_nxt       = neg_r ? (~qmag + 1'b1) : qmag;
          ctl_nxt      = CT_RUN;
        end
      end
      default: ctl_nxt = CT_RUN;
    endcase
  end

  assign out_valid        = ov_r;
  assign out_sck          = osck_r;
  assign out_busy_res     = obusy_r;
  assign out_result_valid = orv_r;
  assign out_weight       = $signed(ow_r);

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (ctl_r == CT_DIV))
    else $error("divider running outside divide phase");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_valid) |-> (!out_busy_res && !out_sck))
    else $error("weight reported while busy or clock high");

  a_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_valid) |-> (out_weight == '0))
    else $error("nonzero weight without result");

  a_power_down: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_power_down) |=> (out_valid && out_sck && !out_busy_res && !out_result_valid))
    else $error("power down not reflected on next result");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for load_cell_adc_serial_reader, ticks driven through the request channel
// depends on lcr_pkg and the reader rtl; the tick behavior is predicted in place and every
// result is compared field by field, with random sender gaps and receiver stalls in two traffic runs
module tb;
  import lcr_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_TICKS = 25;

  typedef struct {
    bit                          sck;
    bit                          busy;
    bit                          valid;
    logic signed [WEIGHT_W-1:0]  weight;
  } tick_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_start_req;
  logic in_dout;
  logic in_power_down;
  logic out_valid;
  logic out_stall;
  logic out_sck;
  logic out_busy_res;
  logic out_result_valid;
  logic signed [WEIGHT_W-1:0] out_weight;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predicted reader state and register mirror
  phase_t ph;
  int bit_cnt;
  logic [SAMPLE_BITS-1:0] shift_word;
  logic [1:0] extra_cnt;
  bit sck_lvl;
  logic signed [TARE_W-1:0] tare_reg;
  logic [DIV_W-1:0] div_reg;
  bit gain_reg;

  tick_result_t pending[$];
  int tx_idle_pct;
  int rx_stall_pct;
  int fail_count;
  int ticks_sent;
  int results_checked;
  int weights_checked;
  int aborted_reads;
  int cycle_count;

  load_cell_adc_serial_reader #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_req     (in_start_req),
    .in_dout          (in_dout),
    .in_power_down    (in_power_down),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sck          (out_sck),
    .out_busy_res     (out_busy_res),
    .out_result_valid (out_result_valid),
    .out_weight       (out_weight),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  function automatic logic signed [WEIGHT_W-1:0] scaled_weight();
    logic signed [SAMPLE_BITS-1:0] raw_s;
    longint raw;
    longint tare;
    longint dv;
    longint q;
    raw_s = shift_word;
    raw = longint'(raw_s);
    tare = longint'(tare_reg);
    dv = longint'(div_reg);
    if (dv == 0) dv = longint'(1);
    q = (raw - tare) / dv;
    if (q > WEIGHT_MAX) q = longint'(WEIGHT_MAX);
    if (q < -WEIGHT_MAX) q = -longint'(WEIGHT_MAX);
    return q[WEIGHT_W-1:0];
  endfunction

  task automatic predict_tick(input bit s, input bit d, input bit p);
    tick_result_t r;
    r.valid = 1'b0;
    r.weight = '0;
    if (p) begin
      ph = PH_IDLE;
      bit_cnt = 0;
      extra_cnt = 2'd0;
      sck_lvl = 1'b1;
    end else begin
      if (ph == PH_IDLE) begin
        sck_lvl = 1'b0;
        if (s) ph = PH_WAIT;
      end
      case (ph)
        PH_WAIT: begin
          if (!d) begin
            sck_lvl = 1'b1;
            bit_cnt = 0;
            shift_word = '0;
            ph = PH_SHIFT;
          end
        end
        PH_SHIFT: begin
          if (sck_lvl) begin
            shift_word = {shift_word[SAMPLE_BITS-2:0], d};
            sck_lvl = 1'b0;
            if (bit_cnt + 1 >= SAMPLE_BITS) begin
              bit_cnt = 0;
              extra_cnt = gain_reg ? 2'd3 : 2'd1;
              ph = PH_EXTRA;
            end else begin
              bit_cnt++;
            end
          end else begin
            sck_lvl = 1'b1;
          end
        end
        PH_EXTRA: begin
          if (sck_lvl) begin
            sck_lvl = 1'b0;
            extra_cnt = extra_cnt - 2'd1;
            if (extra_cnt == 2'd0) ph = PH_DONE;
          end else begin
            sck_lvl = 1'b1;
          end
        end
        PH_DONE: begin
          r.weight = scaled_weight();
          r.valid = 1'b1;
          sck_lvl = 1'b0;
          ph = PH_IDLE;
        end
        default: ;
      endcase
    end
    r.sck = sck_lvl;
    r.busy = (ph != PH_IDLE);
    pending.push_back(r);
  endtask

  task automatic send_tick(input bit s, input bit d, input bit p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= s;
    in_dout <= d;
    in_power_down <= p;
    predict_tick(s, d, p);
    ticks_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_TARE:    tare_reg = data;
      CFG_DIVISOR: div_reg = data[DIV_W-1:0];
      CFG_GAIN:    gain_reg = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_calibration(input logic [TARE_W-1:0] tare, input logic [DIV_W-1:0] dv,
                                 input bit gain);
    if (ph != PH_IDLE) send_tick(bit'($urandom_range(1)), bit'($urandom_range(1)), 1'b1);
    drain_results();
    write_reg(CFG_TARE, tare);
    write_reg(CFG_DIVISOR, {1'b0, dv});
    write_reg(CFG_GAIN, {23'd0, gain});
  endtask

  // one conversion: start, ready wait, 24 data pulses, gain pulses, weight tick; abort_at powers down
  task automatic run_read(input logic [SAMPLE_BITS-1:0] word, input int waits, input int abort_at);
    bit s;
    bit d;
    bit first;
    int k;
    if (ph != PH_IDLE) send_tick(1'b0, bit'($urandom_range(1)), 1'b1);
    first = 1'b1;
    k = 0;
    do begin
      if (k == abort_at) begin
        send_tick(bit'($urandom_range(1)), bit'($urandom_range(1)), 1'b1);
        aborted_reads++;
        break;
      end
      if (ph == PH_IDLE || ph == PH_WAIT) begin
        d = (waits > 0);
        waits--;
      end else if (ph == PH_SHIFT && sck_lvl) begin
        d = word[SAMPLE_BITS-1-bit_cnt];
      end else begin
        d = bit'($urandom_range(1));
      end
      s = first ? 1'b1 : bit'($urandom_range(1));
      first = 1'b0;
      send_tick(s, d, 1'b0);
      k++;
    end while (ph != PH_IDLE);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    tick_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        note_failure($sformatf("unexpected result sck=%0b busy=%0b valid=%0b weight=%0d",
                               out_sck, out_busy_res, out_result_valid, out_weight));
      end else begin
        exp_r = pending.pop_front();
        results_checked++;
        if (exp_r.valid) weights_checked++;
        if (out_sck !== exp_r.sck || out_busy_res !== exp_r.busy ||
            out_result_valid !== exp_r.valid || out_weight !== exp_r.weight)
          note_failure($sformatf(
            "result %0d exp sck=%0b busy=%0b valid=%0b weight=%0d got %0b %0b %0b %0d",
            results_checked, exp_r.sck, exp_r.busy, exp_r.valid, exp_r.weight,
            out_sck, out_busy_res, out_result_valid, out_weight));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_idle_ticks();
    repeat (6) send_tick(1'b0, bit'($urandom_range(1)), 1'b0);
  endtask

  task automatic test_directed_reads();
    // full-scale positive and negative weights, the first with immediate ready on the start tick
    set_calibration(24'h800000, 23'd1, 1'b0);
    run_read(24'h7FFFFF, 0, -1);
    set_calibration(24'h7FFFFF, 23'd1, 1'b1);
    run_read(24'h800000, 2, -1);
    // zero divisor acts as one
    set_calibration(24'h000123, 23'd0, 1'b0);
    run_read(24'hFFFFFF, 1, -1);
    // truncation toward zero of a negative quotient
    set_calibration(24'h000000, 23'd7, 1'b0);
    run_read(24'hFFFFF6, 0, -1);
    set_calibration(24'h000000, 23'h7FFFFF, 1'b1);
    run_read(24'h000000, 3, -1);
  endtask

  // power down mid-read, held, released, then on the weight tick itself
  task automatic test_power_down();
    run_read(SAMPLE_BITS'($urandom), 1, 20);
    repeat (3) send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    run_read(SAMPLE_BITS'($urandom), 0, -1);
    run_read(SAMPLE_BITS'($urandom), 0, 54);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int start_ticks;
    logic [TARE_W-1:0] tare;
    logic [DIV_W-1:0] dv;
    logic [SAMPLE_BITS-1:0] word;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < RANDOM_TICKS) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: tare = 24'h800000;
          1: tare = 24'h7FFFFF;
          default: tare = TARE_W'($urandom);
        endcase
        case ($urandom_range(7))
          0: dv = '0;
          1: dv = 23'h7FFFFF;
          2, 3: dv = DIV_W'($urandom_range(16, 1));
          4: dv = DIV_W'($urandom_range(4096, 1));
          default: dv = DIV_W'($urandom);
        endcase
        set_calibration(tare, dv, bit'($urandom_range(1)));
      end
      case ($urandom_range(7))
        0: word = 24'h800000;
        1: word = 24'h7FFFFF;
        default: word = SAMPLE_BITS'($urandom);
      endcase
      case ($urandom_range(9))
        0: run_read(word, int'($urandom_range(4)), int'($urandom_range(60, 1)));
        1: repeat ($urandom_range(10, 3))
             send_tick(bit'($urandom_range(1)), bit'($urandom_range(1)),
                       $urandom_range(4) == 0);
        default: run_read(word, int'($urandom_range(4)), -1);
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_req = 1'b0;
    in_dout = 1'b1;
    in_power_down = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    fail_count = 0;
    ticks_sent = 0;
    results_checked = 0;
    weights_checked = 0;
    aborted_reads = 0;
    ph = PH_IDLE;
    bit_cnt = 0;
    shift_word = '0;
    extra_cnt = 2'd0;
    sck_lvl = 1'b0;
    tare_reg = '0;
    div_reg = 23'd1;
    gain_reg = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_directed_reads();
    test_power_down();
    test_random_traffic(32, 47);
    test_random_traffic(47, 32);
    test_random_traffic(0, 0);

    drain_results();
    repeat (40) @(posedge clk);
    $display("ran %0d ticks, checked %0d results including %0d weights, %0d reads aborted",
             ticks_sent, results_checked, weights_checked, aborted_reads);
    $display("tare, divisor and gain swept to extremes under three pacing mixes");
    if (fail_count == 0 && pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== load_cell_adc_serial_reader.f =====
rtl/lcr_pkg.sv
rtl/lcr_div.sv
rtl/load_cell_adc_serial_reader.sv
tb/sv/tb.sv
